>>> hw/rtl/nps_pkg.sv
`default_nettype none

package nps_pkg;

  // Storage geometry.
  localparam int MAX_LEN      = 16;
  localparam int ELEMENT_BITS = 16;
  localparam int IDX_BITS     = $clog2(MAX_LEN);
  localparam int LEN_BITS     = IDX_BITS + 1;
  localparam int SWAP_BITS    = 4;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_FIRST,
    ST_SCAN,
    ST_FIND,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_NONEXT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic scan_first;
    logic scan;
    logic find;
    logic copy_rd;
    logic copy_wr;
    logic emit_none;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_short;
    logic scan_hit;
    logic idx_zero;
    logic find_hit;
    logic copy_emit;
    logic copy_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/nps_ram.sv
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nps_ctrl.sv
`default_nettype none

module nps_ctrl
  import nps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       command,
  output logic            in_stall,
  output dp_cmd_t         cmd,
  input  wire dp_status_t st
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && command == CMD_STEP) begin
          state_next = st.n_short ? ST_NONEXT : ST_SCAN_FIRST;
        end
      end
      ST_SCAN_FIRST: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (st.scan_hit) begin
          state_next = ST_FIND;
        end else if (st.idx_zero) begin
          state_next = ST_NONEXT;
        end
      end
      ST_FIND: begin
        if (st.find_hit) begin
          state_next = ST_COPY_RD;
        end
      end
      ST_COPY_RD: begin
        state_next = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        if (!st.copy_emit || st.out_free) begin
          state_next = st.copy_end ? ST_IDLE : ST_COPY_RD;
        end
      end
      ST_NONEXT: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic: datapath commands and input stall.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid && command == CMD_LOAD;
        cmd.start = in_valid && command == CMD_STEP && !st.n_short;
      end
      ST_SCAN_FIRST: begin
        cmd.scan_first = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FIND: begin
        cmd.find = 1'b1;
      end
      ST_COPY_RD: begin
        cmd.copy_rd = 1'b1;
      end
      ST_COPY_WR: begin
        cmd.copy_wr = !st.copy_emit || st.out_free;
      end
      ST_NONEXT: begin
        cmd.emit_none = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/nps_datapath.sv
`default_nettype none

module nps_datapath
  import nps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 cmd,
  output dp_status_t                   st,
  input  wire logic                    cfg_we,
  input  wire logic [LEN_BITS-1:0]     cfg_len,
  input  wire logic [IDX_BITS-1:0]     position,
  input  wire logic [ELEMENT_BITS-1:0] value,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic [IDX_BITS-1:0]          out_position,
  output logic [ELEMENT_BITS-1:0]      out_value,
  output logic                         last,
  output logic                         no_next,
  output logic [SWAP_BITS-1:0]         step_swaps,
  output logic                         parity_odd
);

  // Control state.
  logic [LEN_BITS-1:0] len_reg;
  logic                bank;
  logic [MAX_LEN-1:0]  valid;
  logic                parity;

  // Step working registers.
  logic [LEN_BITS-1:0]     n_q;
  logic [IDX_BITS-1:0]     idx;
  logic [IDX_BITS-1:0]     j_idx;
  logic [IDX_BITS-1:0]     k_idx;
  logic [IDX_BITS-1:0]     p_idx;
  logic [ELEMENT_BITS-1:0] prev;
  logic [ELEMENT_BITS-1:0] piv_val;
  logic [SWAP_BITS-1:0]    swaps_q;
  logic                    rd_valid_q;

  // Memory ports.
  logic                    re;
  logic [IDX_BITS-1:0]     raddr;
  logic                    we0, we1;
  logic [IDX_BITS-1:0]     waddr;
  logic [ELEMENT_BITS-1:0] wdata;
  logic [ELEMENT_BITS-1:0] rdata0, rdata1;

  // Derived values.
  logic [LEN_BITS-1:0]     n_cur;
  logic [ELEMENT_BITS-1:0] rd_val;
  logic [LEN_BITS:0]       src_full;
  logic [IDX_BITS-1:0]     src;
  logic                    p_gt_j;
  logic                    use_piv;
  logic [ELEMENT_BITS-1:0] copy_val;
  logic [LEN_BITS-1:0]     tail_len;
  logic [SWAP_BITS-1:0]    swaps_new;

  // Two banks: a step reads the current one and writes the permuted sequence
  // into the other, so no element is overwritten before it is read.
  nps_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_LEN)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata0)
  );

  nps_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_LEN)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata1)
  );

  // Active length: zero acts as one, large values saturate.
  always_comb begin
    if (len_reg == '0) begin
      n_cur = LEN_BITS'(1);
    end else if (len_reg > LEN_BITS'(MAX_LEN)) begin
      n_cur = LEN_BITS'(MAX_LEN);
    end else begin
      n_cur = len_reg;
    end
  end

  // Entries never written since reset read as zero.
  assign rd_val = rd_valid_q ? (bank ? rdata1 : rdata0) : '0;

  // Source of new element p: head kept, pivot gets the partner, tail reversed.
  assign p_gt_j   = p_idx > j_idx;
  assign src_full = {1'b0, n_q} + {2'b0, j_idx} - {2'b0, p_idx};
  always_comb begin
    if (!st.copy_emit || p_idx < j_idx) begin
      src = p_idx;
    end else if (p_idx == j_idx) begin
      src = k_idx;
    end else begin
      src = src_full[IDX_BITS-1:0];
    end
  end
  // The reversed slot that maps onto the partner receives the old pivot.
  assign use_piv  = st.copy_emit && p_gt_j && src_full[IDX_BITS-1:0] == k_idx;
  assign copy_val = use_piv ? piv_val : rd_val;

  // One pivot swap plus half the tail length for the reversal.
  assign tail_len  = n_q - LEN_BITS'(1) - {1'b0, j_idx};
  assign swaps_new = SWAP_BITS'(1) + SWAP_BITS'(tail_len[LEN_BITS-1:1]);

  // Status to the controller.
  always_comb begin
    st.n_short   = n_cur < LEN_BITS'(2);
    st.scan_hit  = rd_val < prev;
    st.idx_zero  = idx == '0;
    st.find_hit  = rd_val > piv_val;
    st.copy_emit = {1'b0, p_idx} < n_q;
    st.copy_end  = p_idx == IDX_BITS'(MAX_LEN - 1);
    st.out_free  = !out_valid || !out_stall;
  end

  // Read address selection.
  always_comb begin
    re    = 1'b0;
    raddr = idx - IDX_BITS'(1);
    if (cmd.start) begin
      re    = 1'b1;
      raddr = IDX_BITS'(n_cur - LEN_BITS'(1));
    end else if (cmd.scan_first) begin
      re = 1'b1;
    end else if (cmd.scan) begin
      re = 1'b1;
      if (st.scan_hit) begin
        raddr = IDX_BITS'(n_q - LEN_BITS'(1));
      end
    end else if (cmd.find) begin
      re = !st.find_hit;
    end else if (cmd.copy_rd) begin
      re    = 1'b1;
      raddr = src;
    end
  end

  // Write port: loads go to both banks, the copy to the idle bank.
  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = p_idx;
    wdata = copy_val;
    if (cmd.load) begin
      we0   = 1'b1;
      we1   = 1'b1;
      waddr = position;
      wdata = value;
    end else if (cmd.copy_wr) begin
      we0 = bank;
      we1 = !bank;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg   <= LEN_BITS'(MAX_LEN);
      bank      <= 1'b0;
      valid     <= '0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_reg <= cfg_len;
      end
      if (cmd.load) begin
        valid[position] <= 1'b1;
        parity          <= 1'b0;
      end
      if (cmd.find && st.find_hit) begin
        parity <= parity ^ swaps_new[0];
      end
      if (cmd.copy_wr && st.copy_end) begin
        bank  <= !bank;
        valid <= '1;
      end
      if ((cmd.copy_wr && st.copy_emit) || cmd.emit_none) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of a step.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_valid_q <= valid[raddr];
    end
    if (cmd.start) begin
      n_q <= n_cur;
      idx <= IDX_BITS'(n_cur - LEN_BITS'(1));
    end
    if (cmd.scan_first) begin
      prev <= rd_val;
      idx  <= raddr;
    end
    if (cmd.scan) begin
      if (st.scan_hit) begin
        j_idx   <= idx;
        piv_val <= rd_val;
      end else begin
        prev <= rd_val;
      end
      idx <= raddr;
    end
    if (cmd.find) begin
      if (st.find_hit) begin
        k_idx   <= idx;
        swaps_q <= swaps_new;
        p_idx   <= '0;
      end else begin
        idx <= raddr;
      end
    end
    if (cmd.copy_wr) begin
      p_idx <= p_idx + IDX_BITS'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.copy_wr && st.copy_emit) begin
      out_position <= p_idx;
      out_value    <= copy_val;
      last         <= ({1'b0, p_idx} + LEN_BITS'(1)) == n_q;
      no_next      <= 1'b0;
      step_swaps   <= swaps_q;
      parity_odd   <= parity;
    end else if (cmd.emit_none) begin
      out_position <= '0;
      out_value    <= '0;
      last         <= 1'b1;
      no_next      <= 1'b1;
      step_swaps   <= '0;
      parity_odd   <= parity;
    end
  end

`ifndef SYNTH
  // The swap partner always lies to the right of the pivot.
  a_partner_right: assert property (@(posedge clk) disable iff (rst)
    cmd.find && st.find_hit |-> idx > j_idx)
    else $error("swap partner not right of pivot");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.copy_wr && st.copy_emit) || cmd.emit_none |-> !out_valid || !out_stall)
    else $error("result register overwritten while stalled");

  // A no-next result stands alone and reports no swaps.
  a_nonext_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_next |-> last && step_swaps == '0)
    else $error("malformed no-next result");

  // A real step does between one and eight swaps.
  a_swap_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_next |-> step_swaps != '0 && step_swaps <= SWAP_BITS'(8))
    else $error("swap count out of range");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/next_permutation_step.sv
// Next lexicographic permutation engine for a sequence of up to 16 elements.
// Input channel (in_valid/in_stall, fields command, position, value): a load
// transfer writes one element and clears the running swap parity; it produces
// no result. A step transfer advances the sequence.
// Output channel (out_valid/out_stall): a step produces one transfer per
// active element, in position order, with last on the final one; a sequence
// with no ascent produces a single transfer flagged no_next.
// Configuration (cfg_valid/cfg_ready, sequence_length) sets the active length;
// cfg_ready is always high and writes are meant for idle periods.
// Order of a step: the first read, the ascent scan, the partner search, then a
// read and a write for each of all 16 slots of the copy into the other bank
// (one read port per bank). A no-next step ends after the scan, or without
// one when the active length is below two.
// New input is taken only when the controller is idle; one finished result
// waits in the output register while the next step scans.
// When the receiver stalls, the copy pauses on the pending result.
// Reset sets the length to 16, clears the parity and marks all elements as
// zero; no result is pending after reset.
`default_nettype none

module next_permutation_step
  import nps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    command,
  input  wire logic [IDX_BITS-1:0]     position,
  input  wire logic [ELEMENT_BITS-1:0] value,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [LEN_BITS-1:0]     sequence_length,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [IDX_BITS-1:0]          out_position,
  output logic [ELEMENT_BITS-1:0]      out_value,
  output logic                         last,
  output logic                         no_next,
  output logic [SWAP_BITS-1:0]         step_swaps,
  output logic                         parity_odd
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // The length register is always writable.
  assign cfg_ready = 1'b1;

  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  nps_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_len      (sequence_length),
    .position     (position),
    .value        (value),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_position (out_position),
    .out_value    (out_value),
    .last         (last),
    .no_next      (no_next),
    .step_swaps   (step_swaps),
    .parity_odd   (parity_odd)
  );

endmodule

`default_nettype wire

>>> tb/tb_next_permutation_step.sv
`timescale 1ns / 1ps

module tb_next_permutation_step;
  import nps_pkg::*;

  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 200;
  localparam int PLAN_ROWS      = 27;

  // One emitted element of a permutation, as the output channel carries it.
  typedef struct packed {
    logic [IDX_BITS-1:0]     pos;
    logic [ELEMENT_BITS-1:0] val;
    logic                    at_end;
    logic                    no_more;
    logic [SWAP_BITS-1:0]    swaps;
    logic                    odd;
  } perm_result_t;

  // A directed row is either a length write or one input transfer.
  typedef struct packed {
    logic                    is_cfg;
    logic [LEN_BITS-1:0]     cfg_len;
    logic                    cmd;
    logic [IDX_BITS-1:0]     pos;
    logic [ELEMENT_BITS-1:0] val;
    logic                    typed;
    logic                    typed_parity;
  } stim_row_t;

  // Rows marked typed expect a single no_next result with the given parity.
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b1, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd15, 16'hFFFF, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd15, 16'hFFFF, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd7,  16'hA5A5, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd8,  16'h5A5A, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b1, 5'd1,  CMD_LOAD, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd0,  16'h0001, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b1, 1'b0},
    '{1'b1, 5'd0,  CMD_LOAD, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b1, 1'b0},
    '{1'b1, 5'd2,  CMD_LOAD, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd0,  16'h0003, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd1,  16'h0005, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b1, 1'b1},
    '{1'b1, 5'd3,  CMD_LOAD, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd0,  16'h0001, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd1,  16'h0001, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_LOAD, 4'd2,  16'h0002, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b1, 5'd31, CMD_LOAD, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b0, 5'd0,  CMD_STEP, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{1'b1, 5'd16, CMD_LOAD, 4'd0,  16'h0000, 1'b0, 1'b0}
  };

  logic                    clk             = 1'b0;
  logic                    rst             = 1'b1;
  logic                    in_valid        = 1'b0;
  logic                    command         = CMD_LOAD;
  logic [IDX_BITS-1:0]     position        = '0;
  logic [ELEMENT_BITS-1:0] value           = '0;
  logic                    cfg_valid       = 1'b0;
  logic [LEN_BITS-1:0]     sequence_length = LEN_BITS'(16);
  logic                    out_stall       = 1'b0;
  logic                    in_stall;
  logic                    cfg_ready;
  logic                    out_valid;
  logic [IDX_BITS-1:0]     out_position;
  logic [ELEMENT_BITS-1:0] out_value;
  logic                    last;
  logic                    no_next;
  logic [SWAP_BITS-1:0]    step_swaps;
  logic                    parity_odd;

  // Model of the sequence, the running swap parity and the length register.
  logic [ELEMENT_BITS-1:0] seq_model [MAX_LEN];
  logic                    parity_model;
  logic [LEN_BITS-1:0]     length_model;
  perm_result_t            expected_elements [$];
  perm_result_t            head_result;

  bit steady = 1'b0;
  int mismatches    = 0;
  int items_sent    = 0;
  int steps_sent    = 0;
  int results_seen  = 0;
  int no_next_seen  = 0;
  int length_writes = 0;
  int quiet_cycles  = 0;

  next_permutation_step u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .position        (position),
    .value           (value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .sequence_length (sequence_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_position    (out_position),
    .out_value       (out_value),
    .last            (last),
    .no_next         (no_next),
    .step_swaps      (step_swaps),
    .parity_odd      (parity_odd)
  );

  always #2 clk = ~clk;

  // Length in use: zero acts as one, large values saturate.
  function automatic int active_length(input logic [LEN_BITS-1:0] len);
    int n;
    n = int'(len);
    if (n < 1) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    if (n > 16) n = 16;
    return n;
  endfunction

  // Append one result to the tail of the expected queue.
  task automatic queue_expected(input perm_result_t res);
    expected_elements = {expected_elements, res};
  endtask

  task automatic swap_elements(input int a, input int b);
    logic [ELEMENT_BITS-1:0] held;
    held         = seq_model[a];
    seq_model[a] = seq_model[b];
    seq_model[b] = held;
  endtask

  // Apply one accepted transfer to the model and queue the elements it emits.
  task automatic advance_model(input logic cmd, input logic [IDX_BITS-1:0] pos,
                               input logic [ELEMENT_BITS-1:0] val, input bit record);
    int n, j, k, l, r, t, p, swaps;
    bit found;
    perm_result_t res;
    if (cmd == CMD_LOAD) begin
      seq_model[pos] = val;
      parity_model   = 1'b0;
      return;
    end
    n     = active_length(length_model);
    found = 1'b0;
    j     = 0;
    // Scan from the right for the first ascent.
    for (t = n - 1; t > 0 && !found; t--) begin
      if (seq_model[t-1] < seq_model[t]) begin
        j     = t - 1;
        found = 1'b1;
      end
    end
    if (!found) begin
      res = '{pos: '0, val: '0, at_end: 1'b1, no_more: 1'b1, swaps: '0, odd: parity_model};
      if (record) queue_expected(res);
      return;
    end
    // Swap the pivot with its rightmost larger partner, then reverse the tail.
    k = n - 1;
    while (k > j + 1 && seq_model[k] <= seq_model[j]) k--;
    swap_elements(j, k);
    swaps = 1;
    l = j + 1;
    r = n - 1;
    while (l < r) begin
      swap_elements(l, r);
      swaps++;
      l++;
      r--;
    end
    parity_model = parity_model ^ swaps[0];
    if (!record) return;
    for (p = 0; p < n; p++) begin
      res.pos     = p[IDX_BITS-1:0];
      res.val     = seq_model[p];
      res.at_end  = (p == n - 1);
      res.no_more = 1'b0;
      res.swaps   = swaps[SWAP_BITS-1:0];
      res.odd     = parity_model;
      queue_expected(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Offer one transfer, possibly after a random gap, and wait until it is taken.
  task automatic send_item(input logic cmd, input logic [IDX_BITS-1:0] pos,
                           input logic [ELEMENT_BITS-1:0] val, input bit record);
    if (!steady && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == CMD_STEP) steps_sent++;
    advance_model(cmd, pos, val, record);
  endtask

  // Let every expected element arrive, then let the copy pass finish.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_BITS-1:0] len);
    drain_results();
    cfg_valid       <= 1'b1;
    sequence_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    length_model = len;
    length_writes++;
  endtask

  // One random phase: pick a length, load and step a sequence, or send random items.
  task automatic run_episode();
    int pick, n, kind, base, p, steps_n;
    logic [ELEMENT_BITS-1:0] elem;
    pick = $urandom_range(0, 99);
    if (pick < 55) write_length(LEN_BITS'($urandom_range(2, 5)));
    else if (pick < 70) write_length(LEN_BITS'($urandom_range(6, 10)));
    else if (pick < 85) write_length(LEN_BITS'(16));
    else if (pick < 92) write_length(LEN_BITS'($urandom_range(0, 1)));
    else write_length(LEN_BITS'($urandom_range(17, 31)));
    n    = active_length(length_model);
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // Unstructured traffic: random commands, positions and values.
      repeat (8) send_item(1'($urandom_range(0, 1)), IDX_BITS'($urandom_range(0, 15)),
                           ELEMENT_BITS'($urandom), 1'b1);
      return;
    end
    base = $urandom_range(0, 65535 - 16);
    for (p = 0; p < n; p++) begin
      // Few distinct values give repeats; the staircase forces the longest reversal.
      if (kind < 50) elem = ELEMENT_BITS'($urandom_range(0, 3));
      else if (kind < 78) elem = ELEMENT_BITS'($urandom);
      else elem = ELEMENT_BITS'((p == 0) ? base : base + n - p);
      send_item(CMD_LOAD, IDX_BITS'(p), elem, 1'b1);
      if ($urandom_range(0, 9) == 0 && n < MAX_LEN) begin
        send_item(CMD_LOAD, IDX_BITS'($urandom_range(n, MAX_LEN - 1)),
                  ELEMENT_BITS'($urandom), 1'b1);
      end
    end
    steps_n = $urandom_range(1, 10);
    repeat (steps_n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(CMD_LOAD, IDX_BITS'($urandom_range(0, 15)), ELEMENT_BITS'($urandom), 1'b1);
      end
      send_item(CMD_STEP, IDX_BITS'($urandom_range(0, 15)), ELEMENT_BITS'($urandom), 1'b1);
    end
  endtask

  // Receiver stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 27);
  end

  // Check every output transfer and watch for a hung block.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_elements.size() == 0) begin
          report_mismatch($sformatf("unexpected result at position %0d value %0h",
                                    out_position, out_value));
        end else begin
          head_result = expected_elements.pop_front();
          compare_field("out_position", 32'(out_position), 32'(head_result.pos));
          compare_field("out_value", 32'(out_value), 32'(head_result.val));
          compare_field("last", 32'(last), 32'(head_result.at_end));
          compare_field("no_next", 32'(no_next), 32'(head_result.no_more));
          compare_field("step_swaps", 32'(step_swaps), 32'(head_result.swaps));
          compare_field("parity_odd", 32'(parity_odd), 32'(head_result.odd));
          results_seen++;
          if (head_result.no_more) no_next_seen++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL next_permutation_step");
        $finish;
      end
    end
  end

  // Directed table, then random phases, then the final verdict.
  initial begin
    int row, episode, directed_items, i;
    perm_result_t typed_result;
    for (i = 0; i < MAX_LEN; i++) seq_model[i] = '0;
    parity_model = 1'b0;
    length_model = LEN_BITS'(16);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (PLAN[row].is_cfg) begin
        write_length(PLAN[row].cfg_len);
      end else begin
        send_item(PLAN[row].cmd, PLAN[row].pos, PLAN[row].val, !PLAN[row].typed);
        if (PLAN[row].typed) begin
          typed_result = '{pos: '0, val: '0, at_end: 1'b1, no_more: 1'b1, swaps: '0,
                           odd: PLAN[row].typed_parity};
          queue_expected(typed_result);
        end
      end
    end

    directed_items = items_sent;
    episode = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      steady = (episode >= 4 && episode < 8);
      run_episode();
      episode++;
    end
    steady = 1'b0;
    drain_results();

    $display("Sent %0d input transfers (%0d steps) across %0d length writes.",
             items_sent, steps_sent, length_writes);
    $display("Checked %0d output transfers, %0d with no_next; %0d mismatches.",
             results_seen, no_next_seen, mismatches);
    if (mismatches == 0 && expected_elements.size() == 0) begin
      $display("PASS next_permutation_step");
    end else begin
      $display("FAIL next_permutation_step");
    end
    $finish;
  end

endmodule

>>> next_permutation_step.f
hw/rtl/nps_pkg.sv
hw/rtl/nps_ram.sv
hw/rtl/nps_ctrl.sv
hw/rtl/nps_datapath.sv
hw/rtl/next_permutation_step.sv
tb/tb_next_permutation_step.sv
